### rtl/core/mfp_pkg.sv
// mfp_pkg: shared types, codes and helpers for the message frame parser
`timescale 1ns / 1ps

package mfp_pkg;

    // parser phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_HEAD  = 6'b000010,
        PH_INT   = 6'b000100,
        PH_DBL   = 6'b001000,
        PH_SHDR  = 6'b010000,
        PH_SDATA = 6'b100000
    } mfp_phase_t;

    // result kinds
    localparam logic [2:0] KIND_INT   = 3'd0;
    localparam logic [2:0] KIND_DBL   = 3'd1;
    localparam logic [2:0] KIND_SHDR  = 3'd2;
    localparam logic [2:0] KIND_SBYTE = 3'd3;
    localparam logic [2:0] KIND_DONE  = 3'd4;
    localparam logic [2:0] KIND_ERROR = 3'd5;

    // error codes
    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_SHORT      = 4'd1;
    localparam logic [3:0] ERR_INTS       = 4'd2;
    localparam logic [3:0] ERR_DOUBLES    = 4'd3;
    localparam logic [3:0] ERR_STRINGS    = 4'd4;
    localparam logic [3:0] ERR_STR_HEADER = 4'd5;
    localparam logic [3:0] ERR_BAD_LENGTH = 4'd6;
    localparam logic [3:0] ERR_OVERRUN    = 4'd7;
    localparam logic [3:0] ERR_OVER_CAP   = 4'd8;

    // register map (word index from paddr[2])
    localparam logic REG_MAX_STR_LEN = 1'b0;
    localparam logic [31:0] MAX_STR_LEN_RESET = 32'd1048576;

    // framing constants
    localparam logic [31:0] HDR_BYTES      = 32'd12;
    localparam logic [31:0] STR_HDR_BYTES  = 32'd8;
    localparam logic [3:0]  BIE_INT_COUNT  = 4'd4;
    localparam logic [3:0]  BIE_DBL_COUNT  = 4'd8;
    localparam logic [3:0]  BIE_STR_COUNT  = 4'd12;
    localparam logic [3:0]  BIE_INT_END    = 4'd4;
    localparam logic [3:0]  BIE_DBL_END    = 4'd8;
    localparam logic [3:0]  BIE_SHDR_END   = 4'd8;

    // one result word
    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [31:0] idx;
        logic [3:0]  err;
        logic        last;
    } mfp_result_t;

    function automatic mfp_result_t make_result(
        input logic [2:0]  kind,
        input logic [63:0] value,
        input logic [31:0] idx,
        input logic [3:0]  err,
        input logic        last
    );
        mfp_result_t r;
        r.kind  = kind;
        r.value = value;
        r.idx   = idx;
        r.err   = err;
        r.last  = last;
        return r;
    endfunction

endpackage

### rtl/core/message_frame_parser_core.sv
// message_frame_parser_core: byte-serial message parser with result buffer
`timescale 1ns / 1ps

// Byte-wide message parser. The input channel (in_valid / in_stall) carries
// one message byte per word, with first_byte and msg_length sampled on the
// byte that opens a message. The output channel (out_valid / out_stall)
// carries one result per word: ints, double bits, string headers, string
// bytes, and a final done or error word flagged by last.
// Each accepted byte is parsed in the cycle it is accepted and its results
// (zero, one or two) are written into a four-entry result buffer, from which
// the output channel reads them in order.
// Throughput: one byte per cycle while in_stall is low. The input stalls only
// while the result buffer holds three or more words, so the second result of
// a byte is absorbed by the buffer and holds the input back only if the output side also stalls.
// Stalls on the output simply fill the buffer; nothing is dropped.
// Reset empties the buffer, returns the parser to idle (bytes dropped until
// a first_byte) and sets max_string_length to 1048576. The APB port has a
// single register, max_string_length, at byte address 0; pready is always 1.
module message_frame_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic [31:0] msg_length,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  out_kind,
    output logic [63:0] value,
    output logic [31:0] elem_index,
    output logic [3:0]  error_code,
    output logic        last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int BUF_DEPTH = 4;
    localparam int PTR_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam logic [CNT_W-1:0] STALL_LEVEL = CNT_W'(BUF_DEPTH - 2);

    // configuration register
    logic [31:0] max_len_reg;

    // parser state
    mfp_pkg::mfp_phase_t phase_reg, phase_next;
    logic [3:0]  bie_reg, bie_next;
    logic [63:0] shift_reg, shift_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] int_cnt_reg, int_cnt_next;
    logic [31:0] dbl_cnt_reg, dbl_cnt_next;
    logic [31:0] str_cnt_reg, str_cnt_next;
    logic [31:0] elem_reg, elem_next;
    logic [31:0] sleft_reg, sleft_next;
    // header bound checks, worked out as each count arrives
    logic [31:0] hdr_rem_reg, hdr_rem_next;
    logic [31:0] rem1_reg, rem1_next;
    logic [31:0] rem2_reg, rem2_next;
    logic        err2_reg, err2_next;
    logic        err3_reg, err3_next;

    // per-byte working signals
    logic                in_acc;
    mfp_pkg::mfp_phase_t proc_phase;
    logic [3:0]          proc_bie;
    logic [63:0]         proc_shift;
    logic [31:0]         proc_rem;
    logic [31:0]         rem_dec;
    logic [63:0]         shift_sh;
    logic [3:0]          bie_inc;
    logic [31:0]         elem_inc;
    logic [31:0]         str_len;
    logic [31:0]         str_wr;
    logic                ns_go;
    logic                ns_slot1;
    logic [31:0]         ns_elem;
    mfp_pkg::mfp_result_t res0, res1, ns_res;
    logic                res0_vld, res1_vld, ns_vld;

    // result buffer
    mfp_pkg::mfp_result_t buf_reg [BUF_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic             out_acc;
    mfp_pkg::mfp_result_t head;

    // apb access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == mfp_pkg::REG_MAX_STR_LEN) ? max_len_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= mfp_pkg::MAX_STR_LEN_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == mfp_pkg::REG_MAX_STR_LEN))
        begin
            max_len_reg <= pwdata;
        end
    end

    // handshake
    assign in_stall = (cnt_reg > STALL_LEVEL);
    assign in_acc   = in_valid && !in_stall;
    assign out_valid = (cnt_reg != '0);
    assign out_acc   = out_valid && !out_stall;

    // parse one byte
    always_comb
    begin
        phase_next   = phase_reg;
        bie_next     = bie_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        int_cnt_next = int_cnt_reg;
        dbl_cnt_next = dbl_cnt_reg;
        str_cnt_next = str_cnt_reg;
        elem_next    = elem_reg;
        sleft_next   = sleft_reg;
        hdr_rem_next = hdr_rem_reg;
        rem1_next    = rem1_reg;
        rem2_next    = rem2_reg;
        err2_next    = err2_reg;
        err3_next    = err3_reg;

        res0     = '0;
        res1     = '0;
        res0_vld = 1'b0;
        res1_vld = 1'b0;
        ns_res   = '0;
        ns_vld   = 1'b0;
        ns_go    = 1'b0;
        ns_slot1 = 1'b0;
        ns_elem  = '0;
        str_len  = '0;
        str_wr   = '0;

        proc_phase = in_acc ? phase_reg : mfp_pkg::PH_IDLE;
        proc_bie   = bie_reg;
        proc_shift = shift_reg;
        proc_rem   = rem_reg;

        // start of a new message
        if (in_acc && first_byte)
        begin
            elem_next    = '0;
            sleft_next   = '0;
            int_cnt_next = '0;
            dbl_cnt_next = '0;
            str_cnt_next = '0;
            if (msg_length < mfp_pkg::HDR_BYTES)
            begin
                res0 = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, 32'd0,
                                            mfp_pkg::ERR_SHORT, 1'b1);
                res0_vld   = 1'b1;
                phase_next = mfp_pkg::PH_IDLE;
                proc_phase = mfp_pkg::PH_IDLE;
            end
            else
            begin
                proc_phase   = mfp_pkg::PH_HEAD;
                phase_next   = mfp_pkg::PH_HEAD;
                proc_bie     = '0;
                proc_shift   = '0;
                proc_rem     = msg_length;
                hdr_rem_next = msg_length - mfp_pkg::HDR_BYTES;
            end
        end

        rem_dec  = (proc_rem != '0) ? (proc_rem - 32'd1) : proc_rem;
        shift_sh = {proc_shift[55:0], data_byte};
        bie_inc  = proc_bie + 4'd1;
        elem_inc = elem_reg + 32'd1;

        if (proc_phase != mfp_pkg::PH_IDLE)
        begin
            rem_next = rem_dec;
        end

        unique case (proc_phase)
            mfp_pkg::PH_IDLE:
            begin
            end

            // string data bytes
            mfp_pkg::PH_SDATA:
            begin
                res0 = mfp_pkg::make_result(mfp_pkg::KIND_SBYTE, {56'd0, data_byte},
                                            shift_reg[31:0] - sleft_reg,
                                            mfp_pkg::ERR_NONE, 1'b0);
                res0_vld   = 1'b1;
                sleft_next = sleft_reg - 32'd1;
                if (sleft_reg == 32'd1)
                begin
                    elem_next = elem_inc;
                    ns_go     = 1'b1;
                    ns_slot1  = 1'b1;
                    ns_elem   = elem_inc;
                end
            end

            // three count words, bound checks built up as they land
            mfp_pkg::PH_HEAD:
            begin
                shift_next = shift_sh;
                bie_next   = bie_inc;
                if (bie_inc == mfp_pkg::BIE_INT_COUNT)
                begin
                    int_cnt_next = shift_sh[31:0];
                    err2_next    = shift_sh[31:0] > {2'b00, hdr_rem_reg[31:2]};
                    rem1_next    = hdr_rem_reg - {shift_sh[29:0], 2'b00};
                end
                else if (bie_inc == mfp_pkg::BIE_DBL_COUNT)
                begin
                    dbl_cnt_next = shift_sh[31:0];
                    err3_next    = shift_sh[31:0] > {3'b000, rem1_reg[31:3]};
                    rem2_next    = rem1_reg - {shift_sh[28:0], 3'b000};
                end
                else if (bie_inc == mfp_pkg::BIE_STR_COUNT)
                begin
                    str_cnt_next = shift_sh[31:0];
                    if (err2_reg)
                    begin
                        res0 = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, 32'd0,
                                                    mfp_pkg::ERR_INTS, 1'b1);
                        res0_vld   = 1'b1;
                        phase_next = mfp_pkg::PH_IDLE;
                    end
                    else if (err3_reg)
                    begin
                        res0 = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, 32'd0,
                                                    mfp_pkg::ERR_DOUBLES, 1'b1);
                        res0_vld   = 1'b1;
                        phase_next = mfp_pkg::PH_IDLE;
                    end
                    else if (shift_sh[31:0] > {3'b000, rem2_reg[31:3]})
                    begin
                        res0 = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, 32'd0,
                                                    mfp_pkg::ERR_STRINGS, 1'b1);
                        res0_vld   = 1'b1;
                        phase_next = mfp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        elem_next = '0;
                        bie_next  = '0;
                        if (int_cnt_reg != '0)
                        begin
                            phase_next = mfp_pkg::PH_INT;
                        end
                        else if (dbl_cnt_reg != '0)
                        begin
                            phase_next = mfp_pkg::PH_DBL;
                        end
                        else
                        begin
                            ns_go   = 1'b1;
                            ns_elem = '0;
                        end
                    end
                end
            end

            // 32-bit ints
            mfp_pkg::PH_INT:
            begin
                shift_next = shift_sh;
                bie_next   = bie_inc;
                if (bie_inc == mfp_pkg::BIE_INT_END)
                begin
                    res0 = mfp_pkg::make_result(mfp_pkg::KIND_INT, {32'd0, shift_sh[31:0]},
                                                elem_reg, mfp_pkg::ERR_NONE, 1'b0);
                    res0_vld = 1'b1;
                    bie_next = '0;
                    if (elem_inc >= int_cnt_reg)
                    begin
                        elem_next = '0;
                        if (dbl_cnt_reg != '0)
                        begin
                            phase_next = mfp_pkg::PH_DBL;
                        end
                        else
                        begin
                            ns_go    = 1'b1;
                            ns_slot1 = 1'b1;
                            ns_elem  = '0;
                        end
                    end
                    else
                    begin
                        elem_next = elem_inc;
                    end
                end
            end

            // 64-bit doubles as raw bits
            mfp_pkg::PH_DBL:
            begin
                shift_next = shift_sh;
                bie_next   = bie_inc;
                if (bie_inc == mfp_pkg::BIE_DBL_END)
                begin
                    res0 = mfp_pkg::make_result(mfp_pkg::KIND_DBL, shift_sh, elem_reg,
                                                mfp_pkg::ERR_NONE, 1'b0);
                    res0_vld = 1'b1;
                    bie_next = '0;
                    if (elem_inc >= dbl_cnt_reg)
                    begin
                        elem_next = '0;
                        ns_go     = 1'b1;
                        ns_slot1  = 1'b1;
                        ns_elem   = '0;
                    end
                    else
                    begin
                        elem_next = elem_inc;
                    end
                end
            end

            // string length and written byte count
            mfp_pkg::PH_SHDR:
            begin
                shift_next = shift_sh;
                bie_next   = bie_inc;
                str_len    = shift_sh[63:32];
                str_wr     = shift_sh[31:0];
                if (bie_inc == mfp_pkg::BIE_SHDR_END)
                begin
                    bie_next = '0;
                    if ((str_len == '0) || (str_wr >= str_len))
                    begin
                        res0 = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, elem_reg,
                                                    mfp_pkg::ERR_BAD_LENGTH, 1'b1);
                        res0_vld   = 1'b1;
                        phase_next = mfp_pkg::PH_IDLE;
                    end
                    else if (str_wr > rem_dec)
                    begin
                        res0 = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, elem_reg,
                                                    mfp_pkg::ERR_OVERRUN, 1'b1);
                        res0_vld   = 1'b1;
                        phase_next = mfp_pkg::PH_IDLE;
                    end
                    else if (str_len > max_len_reg)
                    begin
                        res0 = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, elem_reg,
                                                    mfp_pkg::ERR_OVER_CAP, 1'b1);
                        res0_vld   = 1'b1;
                        phase_next = mfp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        res0 = mfp_pkg::make_result(mfp_pkg::KIND_SHDR, {32'd0, str_wr},
                                                    elem_reg, mfp_pkg::ERR_NONE, 1'b0);
                        res0_vld = 1'b1;
                        if (str_wr == '0)
                        begin
                            elem_next = elem_inc;
                            ns_go     = 1'b1;
                            ns_slot1  = 1'b1;
                            ns_elem   = elem_inc;
                        end
                        else
                        begin
                            phase_next = mfp_pkg::PH_SDATA;
                            sleft_next = str_wr;
                        end
                    end
                end
            end

            default:
            begin
            end
        endcase

        // move on to the next string or close the message
        if (ns_go)
        begin
            if (ns_elem >= str_cnt_next)
            begin
                ns_res = mfp_pkg::make_result(mfp_pkg::KIND_DONE, 64'd0, 32'd0,
                                              mfp_pkg::ERR_NONE, 1'b1);
                ns_vld     = 1'b1;
                phase_next = mfp_pkg::PH_IDLE;
            end
            else if (rem_dec < mfp_pkg::STR_HDR_BYTES)
            begin
                ns_res = mfp_pkg::make_result(mfp_pkg::KIND_ERROR, 64'd0, ns_elem,
                                              mfp_pkg::ERR_STR_HEADER, 1'b1);
                ns_vld     = 1'b1;
                phase_next = mfp_pkg::PH_IDLE;
            end
            else
            begin
                phase_next = mfp_pkg::PH_SHDR;
                bie_next   = '0;
                shift_next = '0;
            end
            if (ns_slot1)
            begin
                res1     = ns_res;
                res1_vld = ns_vld;
            end
            else
            begin
                res0     = ns_res;
                res0_vld = ns_vld;
            end
        end
    end

    // parser control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= mfp_pkg::PH_IDLE;
            bie_reg     <= '0;
            rem_reg     <= '0;
            int_cnt_reg <= '0;
            dbl_cnt_reg <= '0;
            str_cnt_reg <= '0;
            elem_reg    <= '0;
            sleft_reg   <= '0;
            err2_reg    <= 1'b0;
            err3_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bie_reg     <= bie_next;
            rem_reg     <= rem_next;
            int_cnt_reg <= int_cnt_next;
            dbl_cnt_reg <= dbl_cnt_next;
            str_cnt_reg <= str_cnt_next;
            elem_reg    <= elem_next;
            sleft_reg   <= sleft_next;
            err2_reg    <= err2_next;
            err3_reg    <= err3_next;
        end
    end

    // parser data path
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        hdr_rem_reg <= hdr_rem_next;
        rem1_reg    <= rem1_next;
        rem2_reg    <= rem2_next;
    end

    // result buffer pointers
    assign wr_ptr_p1 = wr_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (res0_vld && res1_vld)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(2);
            cnt_next    = cnt_next + CNT_W'(2);
        end
        else if (res0_vld)
        begin
            wr_ptr_next = wr_ptr_p1;
            cnt_next    = cnt_next + CNT_W'(1);
        end
        if (out_acc)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            cnt_next    = cnt_next - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result buffer storage
    always_ff @(posedge clk)
    begin
        if (res0_vld)
        begin
            buf_reg[wr_ptr_reg] <= res0;
        end
        if (res1_vld)
        begin
            buf_reg[wr_ptr_p1] <= res1;
        end
    end

    // output word
    assign head       = buf_reg[rd_ptr_reg];
    assign out_kind   = head.kind;
    assign value      = head.value;
    assign elem_index = head.idx;
    assign error_code = head.err;
    assign last       = head.last;

endmodule

### rtl/core/mfp_checker.sv
// mfp_checker: port-level assertions for the message frame parser
`timescale 1ns / 1ps

module mfp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  out_kind,
    input logic [63:0] value,
    input logic [31:0] elem_index,
    input logic [3:0]  error_code,
    input logic        last
);

    // a stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(value)
            && $stable(elem_index) && $stable(error_code) && $stable(last))
        else $error("output word changed while stalled");

    // last marks exactly the done and error words
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == ((out_kind == mfp_pkg::KIND_DONE)
                                || (out_kind == mfp_pkg::KIND_ERROR))))
        else $error("last flag does not match word kind");

    // an error code travels only with an error word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_kind == mfp_pkg::KIND_ERROR) == (error_code != mfp_pkg::ERR_NONE)))
        else $error("error code does not match word kind");

    // input stalls only while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> out_valid)
        else $error("input stalled with no result pending");

endmodule

bind message_frame_parser_core mfp_checker u_mfp_checker (.*);

### bench/tb_top.sv
// tb_top: self-checking bench for the message frame parser core
`timescale 1ns / 1ps

module tb_top;

    localparam int          STALL_LIMIT = 1000;
    localparam int          SETTLE      = 4;
    localparam logic [2:0]  CAP_ADDR    = {mfp_pkg::REG_MAX_STR_LEN, 2'b00};

    // one row of the directed stimulus
    typedef struct packed {
        logic [7:0]           b;
        logic                 fb;
        logic [31:0]          len;
        logic                 typed;
        mfp_pkg::mfp_result_t want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] msg_length;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  out_kind;
    logic [63:0] value;
    logic [31:0] elem_index;
    logic [3:0]  error_code;
    logic        last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // results the parser still owes, oldest first
    mfp_pkg::mfp_result_t pending[$];
    stim_row_t            dir_rows[$];
    logic [7:0]           msg_bytes[$];
    mfp_pkg::mfp_result_t no_res;

    // shadow parser state
    mfp_pkg::mfp_phase_t parse_ph;
    logic [3:0]  hdr_pos;
    logic [63:0] shift_acc;
    logic [31:0] left_bytes;
    logic [31:0] n_ints;
    logic [31:0] n_dbls;
    logic [31:0] n_strs;
    logic [31:0] elem_no;
    logic [31:0] str_left;
    logic [31:0] cap;

    int mism;
    bit quiet;
    bit gap_on;

    message_frame_parser_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .msg_length (msg_length),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_kind   (out_kind),
        .value      (value),
        .elem_index (elem_index),
        .error_code (error_code),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mism++;
        $display("%0t: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    function automatic void push_result(input logic [2:0] k, input logic [63:0] v,
                                        input logic [31:0] i, input logic [3:0] e,
                                        input logic l);
        mfp_pkg::mfp_result_t r;
        r.kind  = k;
        r.value = v;
        r.idx   = i;
        r.err   = e;
        r.last  = l;
        pending.push_back(r);
    endfunction

    function automatic void end_with_error(input logic [3:0] code, input logic [31:0] i);
        push_result(mfp_pkg::KIND_ERROR, 64'd0, i, code, 1'b1);
        parse_ph = mfp_pkg::PH_IDLE;
    endfunction

    // next string, header room check, or done
    function automatic void open_string();
        if (elem_no >= n_strs)
        begin
            push_result(mfp_pkg::KIND_DONE, 64'd0, 32'd0, mfp_pkg::ERR_NONE, 1'b1);
            parse_ph = mfp_pkg::PH_IDLE;
        end
        else if (left_bytes < mfp_pkg::STR_HDR_BYTES)
            end_with_error(mfp_pkg::ERR_STR_HEADER, elem_no);
        else
        begin
            parse_ph  = mfp_pkg::PH_SHDR;
            hdr_pos   = 4'd0;
            shift_acc = 64'd0;
        end
    endfunction

    function automatic void leave_ints();
        elem_no = 32'd0;
        hdr_pos = 4'd0;
        if (n_dbls != 32'd0)
            parse_ph = mfp_pkg::PH_DBL;
        else
            open_string();
    endfunction

    // expected results for one accepted byte
    function automatic void parse_byte(input logic [7:0] b, input logic fb,
                                       input logic [31:0] len);
        logic [63:0] room;
        logic [31:0] slen;
        logic [31:0] swr;
        if (fb)
        begin
            left_bytes = len;
            n_ints     = 32'd0;
            n_dbls     = 32'd0;
            n_strs     = 32'd0;
            elem_no    = 32'd0;
            str_left   = 32'd0;
            hdr_pos    = 4'd0;
            shift_acc  = 64'd0;
            if (len < mfp_pkg::HDR_BYTES)
            begin
                end_with_error(mfp_pkg::ERR_SHORT, 32'd0);
                return;
            end
            parse_ph = mfp_pkg::PH_HEAD;
        end
        if (parse_ph == mfp_pkg::PH_IDLE)
            return;
        if (left_bytes != 32'd0)
            left_bytes = left_bytes - 32'd1;

        // string payload bytes pass straight through
        if (parse_ph == mfp_pkg::PH_SDATA)
        begin
            push_result(mfp_pkg::KIND_SBYTE, {56'd0, b}, shift_acc[31:0] - str_left,
                        mfp_pkg::ERR_NONE, 1'b0);
            str_left = str_left - 32'd1;
            if (str_left == 32'd0)
            begin
                elem_no = elem_no + 32'd1;
                open_string();
            end
            return;
        end

        shift_acc = {shift_acc[55:0], b};
        hdr_pos   = hdr_pos + 4'd1;
        case (parse_ph)
            mfp_pkg::PH_HEAD:
            begin
                if (hdr_pos == mfp_pkg::BIE_INT_COUNT)
                    n_ints = shift_acc[31:0];
                else if (hdr_pos == mfp_pkg::BIE_DBL_COUNT)
                    n_dbls = shift_acc[31:0];
                else if (hdr_pos == mfp_pkg::BIE_STR_COUNT)
                begin
                    n_strs = shift_acc[31:0];
                    // section sizes against what the length leaves
                    room = {32'd0, left_bytes};
                    if ({32'd0, n_ints} > room / 4)
                    begin
                        end_with_error(mfp_pkg::ERR_INTS, 32'd0);
                        return;
                    end
                    room = room - {32'd0, n_ints} * 4;
                    if ({32'd0, n_dbls} > room / 8)
                    begin
                        end_with_error(mfp_pkg::ERR_DOUBLES, 32'd0);
                        return;
                    end
                    room = room - {32'd0, n_dbls} * 8;
                    if ({32'd0, n_strs} > room / 8)
                    begin
                        end_with_error(mfp_pkg::ERR_STRINGS, 32'd0);
                        return;
                    end
                    elem_no = 32'd0;
                    hdr_pos = 4'd0;
                    if (n_ints != 32'd0)
                        parse_ph = mfp_pkg::PH_INT;
                    else
                        leave_ints();
                end
            end
            mfp_pkg::PH_INT:
            begin
                if (hdr_pos == mfp_pkg::BIE_INT_END)
                begin
                    push_result(mfp_pkg::KIND_INT, {32'd0, shift_acc[31:0]}, elem_no,
                                mfp_pkg::ERR_NONE, 1'b0);
                    hdr_pos = 4'd0;
                    elem_no = elem_no + 32'd1;
                    if (elem_no >= n_ints)
                        leave_ints();
                end
            end
            mfp_pkg::PH_DBL:
            begin
                if (hdr_pos == mfp_pkg::BIE_DBL_END)
                begin
                    push_result(mfp_pkg::KIND_DBL, shift_acc, elem_no, mfp_pkg::ERR_NONE, 1'b0);
                    hdr_pos = 4'd0;
                    elem_no = elem_no + 32'd1;
                    if (elem_no >= n_dbls)
                    begin
                        elem_no = 32'd0;
                        open_string();
                    end
                end
            end
            mfp_pkg::PH_SHDR:
            begin
                if (hdr_pos == mfp_pkg::BIE_SHDR_END)
                begin
                    hdr_pos = 4'd0;
                    slen    = shift_acc[63:32];
                    swr     = shift_acc[31:0];
                    if (slen == 32'd0 || swr >= slen)
                        end_with_error(mfp_pkg::ERR_BAD_LENGTH, elem_no);
                    else if (swr > left_bytes)
                        end_with_error(mfp_pkg::ERR_OVERRUN, elem_no);
                    else if (slen > cap)
                        end_with_error(mfp_pkg::ERR_OVER_CAP, elem_no);
                    else
                    begin
                        push_result(mfp_pkg::KIND_SHDR, {32'd0, swr}, elem_no,
                                    mfp_pkg::ERR_NONE, 1'b0);
                        if (swr == 32'd0)
                        begin
                            elem_no = elem_no + 32'd1;
                            open_string();
                        end
                        else
                        begin
                            parse_ph = mfp_pkg::PH_SDATA;
                            str_left = swr;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void add_row(input logic [7:0] b, input logic fb,
                                    input logic [31:0] len, input logic typed,
                                    input logic [2:0] k, input logic [3:0] e);
        stim_row_t r;
        r.b          = b;
        r.fb         = fb;
        r.len        = len;
        r.typed      = typed;
        r.want.kind  = k;
        r.want.value = 64'd0;
        r.want.idx   = 32'd0;
        r.want.err   = e;
        r.want.last  = 1'b1;
        dir_rows.push_back(r);
    endfunction

    function automatic void put_word(input logic [31:0] w);
        msg_bytes.push_back(w[31:24]);
        msg_bytes.push_back(w[23:16]);
        msg_bytes.push_back(w[15:8]);
        msg_bytes.push_back(w[7:0]);
    endfunction

    // one frame: mostly well formed, the rest cut short or corrupted
    task automatic build_message(output logic [31:0] len_out);
        int          ni;
        int          nd;
        int          ns;
        int          mode;
        int          bad_s;
        int          k;
        int          s;
        int          wr;
        int          cut;
        logic [31:0] bad;
        logic [31:0] sl;
        logic [31:0] hdr_wr;
        msg_bytes.delete();
        mode = $urandom_range(0, 15);
        ni   = $urandom_range(0, 3);
        nd   = $urandom_range(0, 2);
        ns   = $urandom_range(0, 3);
        if (mode == 13 && ns == 0)
            ns = 1;
        bad_s = (ns > 0) ? $urandom_range(0, ns - 1) : 0;
        k     = (mode == 12) ? $urandom_range(0, 2) : 3;
        bad   = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(4, 40);

        put_word((k == 0) ? bad : ni);
        put_word((k == 1) ? bad : nd);
        put_word((k == 2) ? bad : ns);
        repeat (ni) put_word($urandom);
        repeat (nd)
        begin
            put_word($urandom);
            put_word($urandom);
        end
        for (s = 0; s < ns; s++)
        begin
            wr     = $urandom_range(0, 4);
            sl     = wr + 1 + $urandom_range(0, 3);
            hdr_wr = wr;
            if (mode == 13 && s == bad_s)
            begin
                case ($urandom_range(0, 3))
                    0: sl = 32'd0;
                    1: sl = wr;
                    2: sl = $urandom;
                    default:
                    begin
                        hdr_wr = wr + $urandom_range(64, 200);
                        sl     = hdr_wr + 1;
                    end
                endcase
            end
            put_word(sl);
            put_word(hdr_wr);
            repeat (wr) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(0, 255)));

        len_out = msg_bytes.size();
        case (mode)
            10: len_out = $urandom_range(0, 11);
            11:
            begin
                if (msg_bytes.size() > 12)
                    len_out = $urandom_range(12, msg_bytes.size() - 1);
            end
            14:
            begin
                // cut the frame so the next one restarts it
                cut = $urandom_range(1, msg_bytes.size() - 1);
                while (msg_bytes.size() > cut)
                    void'(msg_bytes.pop_back());
            end
            15: len_out = $urandom;
            default:
            begin
            end
        endcase
    endtask

    // offer one word on the input and predict once it is taken
    task automatic send_byte(input logic [7:0] b, input logic fb, input logic [31:0] len,
                             input logic typed, input mfp_pkg::mfp_result_t want);
        int n0;
        if (gap_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        first_byte <= fb;
        msg_length <= len;
        do @(posedge clk); while (in_stall);
        n0 = pending.size();
        parse_byte(b, fb, len);
        if (typed)
        begin
            while (pending.size() > n0)
                void'(pending.pop_back());
            pending.push_back(want);
        end
    endtask

    // hold the input until the parser has caught up
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_cap(output logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAP_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        v = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // output side stalls in bursts, with calm stretches
    initial
    begin : out_side
        int stall_level;
        stall_level = 3;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 39) < stall_level)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 63) == 0)
                stall_level = $urandom_range(0, 6);
        end
    end

    // compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        mfp_pkg::mfp_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
                flag_mismatch("word with nothing pending, out_kind", {61'd0, out_kind}, 64'd0);
            else
            begin
                want = pending.pop_front();
                if (out_kind !== want.kind)
                    flag_mismatch("out_kind", {61'd0, out_kind}, {61'd0, want.kind});
                if (value !== want.value)
                    flag_mismatch("value", value, want.value);
                if (elem_index !== want.idx)
                    flag_mismatch("elem_index", {32'd0, elem_index}, {32'd0, want.idx});
                if (error_code !== want.err)
                    flag_mismatch("error_code", {60'd0, error_code}, {60'd0, want.err});
                if (last !== want.last)
                    flag_mismatch("last", {63'd0, last}, {63'd0, want.last});
            end
        end
    end

    // end the run when nothing moves for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] rd;
        logic [31:0] cap_v;
        logic [31:0] len_v;
        int          pass_i;
        int          msg_i;
        int          sent;

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_byte  <= 8'd0;
        first_byte <= 1'b0;
        msg_length <= 32'd0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= 3'd0;
        pwdata     <= 32'd0;
        mism       = 0;
        quiet      = 1'b0;
        gap_on     = 1'b1;
        no_res     = '0;

        parse_ph   = mfp_pkg::PH_IDLE;
        hdr_pos    = 4'd0;
        shift_acc  = 64'd0;
        left_bytes = 32'd0;
        n_ints     = 32'd0;
        n_dbls     = 32'd0;
        n_strs     = 32'd0;
        elem_no    = 32'd0;
        str_left   = 32'd0;
        cap        = mfp_pkg::MAX_STR_LEN_RESET;

        // byte while idle, two short frames
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b1, 32'd0,        1'b1, mfp_pkg::KIND_ERROR, mfp_pkg::ERR_SHORT);
        add_row(8'h00, 1'b1, 32'd11,       1'b1, mfp_pkg::KIND_ERROR, mfp_pkg::ERR_SHORT);
        // smallest frame: empty header ends in done
        add_row(8'h00, 1'b1, 32'd12,       1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'h00, 1'b0, 32'd0,        1'b1, mfp_pkg::KIND_DONE,  mfp_pkg::ERR_NONE);
        // frame opened, then restarted by the largest length; all-ones counts
        add_row(8'h00, 1'b1, 32'd20,       1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b1, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b0, mfp_pkg::KIND_INT,   mfp_pkg::ERR_NONE);
        add_row(8'hFF, 1'b0, 32'hFFFFFFFF, 1'b1, mfp_pkg::KIND_ERROR, mfp_pkg::ERR_INTS);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_cap(rd);
        if (rd !== mfp_pkg::MAX_STR_LEN_RESET)
            flag_mismatch("max_string_length after reset", {32'd0, rd},
                          {32'd0, mfp_pkg::MAX_STR_LEN_RESET});

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].fb, dir_rows[i].len,
                      dir_rows[i].typed, dir_rows[i].want);

        // random frames under several length caps; the last pass runs without input gaps or output stalls
        for (pass_i = 0; pass_i < 5; pass_i++)
        begin
            case (pass_i)
                0: cap_v = 32'd5;
                1: cap_v = 32'd1;
                2: cap_v = 32'hFFFFFFFF;
                3: cap_v = $urandom_range(2, 8);
                default: cap_v = mfp_pkg::MAX_STR_LEN_RESET;
            endcase
            quiet = (pass_i == 4);
            drain_results();
            apb_write(cap_v);
            cap = cap_v;
            read_cap(rd);
            if (rd !== cap)
                flag_mismatch("max_string_length readback", {32'd0, rd}, {32'd0, cap});

            sent  = 0;
            msg_i = 0;
            while (sent < 80)
            begin
                if (msg_i == 3)
                    drain_results();
                gap_on = !quiet && ($urandom_range(0, 2) != 0);
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 3))
                        send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom, 1'b0, no_res);
                build_message(len_v);
                foreach (msg_bytes[j])
                    send_byte(msg_bytes[j], j == 0, (j == 0) ? len_v : $urandom, 1'b0, no_res);
                sent += msg_bytes.size();
                msg_i++;
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mism == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### message_frame_parser_core.f
rtl/core/mfp_pkg.sv
rtl/core/message_frame_parser_core.sv
rtl/core/mfp_checker.sv
bench/tb_top.sv
